// ===== sv/kwl_pkg.sv =====
// kwl_pkg: shared types, constants and character helpers for the keyword lexer
`default_nettype none

package kwl_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int OFFSET_BITS = 32;
    localparam int KW_COUNT    = 8;
    localparam int OBUF_DEPTH  = 4;
    localparam int PTR_W       = $clog2(OBUF_DEPTH);

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'd0,
        MODE_IDENT = 4'd1,
        MODE_LT    = 4'd2,
        MODE_GT    = 4'd3,
        MODE_BANG  = 4'd4,
        MODE_EQ    = 4'd5,
        MODE_DASH  = 4'd6,
        MODE_AMP   = 4'd7,
        MODE_BAR   = 4'd8
    } mode_t;

    typedef enum logic [5:0] {
        KIND_NUMBER    = 6'd0,
        KIND_FUN       = 6'd1,
        KIND_LET       = 6'd2,
        KIND_IN        = 6'd3,
        KIND_CASE      = 6'd4,
        KIND_OF        = 6'd5,
        KIND_END       = 6'd6,
        KIND_VAR       = 6'd7,
        KIND_TYPE      = 6'd8,
        KIND_UPPERID   = 6'd9,
        KIND_LOWERID   = 6'd10,
        KIND_LE        = 6'd11,
        KIND_LT        = 6'd12,
        KIND_GE        = 6'd13,
        KIND_GT        = 6'd14,
        KIND_NE        = 6'd15,
        KIND_NOT       = 6'd16,
        KIND_FAT_ARROW = 6'd17,
        KIND_EQ        = 6'd18,
        KIND_DEF       = 6'd19,
        KIND_LPAREN    = 6'd20,
        KIND_RPAREN    = 6'd21,
        KIND_COLON     = 6'd22,
        KIND_SEMICOLON = 6'd23,
        KIND_PLUS      = 6'd24,
        KIND_ARROW     = 6'd25,
        KIND_MINUS     = 6'd26,
        KIND_MUL       = 6'd27,
        KIND_DIV       = 6'd28,
        KIND_MOD       = 6'd29,
        KIND_AND       = 6'd30,
        KIND_OR        = 6'd31,
        KIND_PIPE      = 6'd32,
        KIND_EOF       = 6'd33,
        KIND_ERR       = 6'd34
    } kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } char_beat_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [31:0] token_offset;
        logic [15:0] token_size;
        logic        last_of_run;
    } token_t;

    typedef struct packed {
        mode_t                  mode;
        logic                   digits_only;
        logic                   upper_first;
        logic [KW_COUNT-1:0]    kw_alive;
        logic [LENGTH_BITS-1:0] pend_len;
        logic [OFFSET_BITS-1:0] pend_start;
        logic [OFFSET_BITS-1:0] byte_pos;
        logic                   stopped;
    } lex_state_t;

    typedef struct packed {
        logic   v0;
        logic   v1;
        token_t t0;
        token_t t1;
    } tok_pair_t;

    localparam lex_state_t LEX_RESET = '{
        mode:        MODE_IDLE,
        digits_only: 1'b1,
        upper_first: 1'b0,
        kw_alive:    '1,
        pend_len:    '0,
        pend_start:  '0,
        byte_pos:    '0,
        stopped:     1'b0
    };

    function automatic logic decimal_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic capital_letter(input logic [7:0] c);
        return (c >= "A") && (c <= "Z");
    endfunction

    function automatic logic name_char(input logic [7:0] c);
        return (c == "_") || decimal_digit(c) || capital_letter(c)
               || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
    endfunction

    // keyword text, first character in the top byte
    function automatic logic [31:0] kw_text(input logic [2:0] k);
        logic [31:0] w;
        unique case (k)
            3'd0:    w = {"f", "u", "n", 8'h00};
            3'd1:    w = {"l", "e", "t", 8'h00};
            3'd2:    w = {"i", "n", 8'h00, 8'h00};
            3'd3:    w = {"c", "a", "s", "e"};
            3'd4:    w = {"o", "f", 8'h00, 8'h00};
            3'd5:    w = {"e", "n", "d", 8'h00};
            3'd6:    w = {"v", "a", "r", 8'h00};
            3'd7:    w = {"t", "y", "p", "e"};
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [2:0] kw_len(input logic [2:0] k);
        logic [2:0] n;
        unique case (k)
            3'd2, 3'd4: n = 3'd2;
            3'd3, 3'd7: n = 3'd4;
            default:    n = 3'd3;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [1:0] idx);
        logic [31:0] w;
        w = kw_text(k);
        return w[31 - 8 * idx -: 8];
    endfunction

endpackage

`default_nettype wire

// ===== sv/kwl_step.sv =====
// kwl_step: next lexer state and up to two tokens for one input beat
`default_nettype none

module kwl_step (
    input  wire kwl_pkg::lex_state_t cur,
    input  wire kwl_pkg::char_beat_t beat,
    output kwl_pkg::lex_state_t      nxt,
    output kwl_pkg::tok_pair_t       res
);

    function automatic kwl_pkg::lex_state_t add_char(input kwl_pkg::lex_state_t s,
                                                     input logic [7:0] c);
        kwl_pkg::lex_state_t r;
        r = s;
        if (s.pend_len == '0)
        begin
            r.upper_first = kwl_pkg::capital_letter(c);
        end
        if (!kwl_pkg::decimal_digit(c))
        begin
            r.digits_only = 1'b0;
        end
        for (int k = 0; k < kwl_pkg::KW_COUNT; k++)
        begin
            if ((s.pend_len >= kwl_pkg::LENGTH_BITS'(kwl_pkg::kw_len(3'(k))))
                || (kwl_pkg::kw_char(3'(k), s.pend_len[1:0]) != c))
            begin
                r.kw_alive[k] = 1'b0;
            end
        end
        if (s.pend_len != '1)
        begin
            r.pend_len = s.pend_len + 1'b1;
        end
        return r;
    endfunction

    function automatic kwl_pkg::kind_t ident_kind(input kwl_pkg::lex_state_t s);
        kwl_pkg::kind_t kd;
        kd = s.upper_first ? kwl_pkg::KIND_UPPERID : kwl_pkg::KIND_LOWERID;
        for (int k = kwl_pkg::KW_COUNT - 1; k >= 0; k--)
        begin
            if (s.kw_alive[k]
                && (s.pend_len == kwl_pkg::LENGTH_BITS'(kwl_pkg::kw_len(3'(k)))))
            begin
                kd = kwl_pkg::kind_t'(6'(k + 1));
            end
        end
        if (s.digits_only)
        begin
            kd = kwl_pkg::KIND_NUMBER;
        end
        return kd;
    endfunction

    function automatic kwl_pkg::kind_t single_kind(input kwl_pkg::mode_t m);
        kwl_pkg::kind_t kd;
        unique case (m)
            kwl_pkg::MODE_LT:   kd = kwl_pkg::KIND_LT;
            kwl_pkg::MODE_GT:   kd = kwl_pkg::KIND_GT;
            kwl_pkg::MODE_BANG: kd = kwl_pkg::KIND_NOT;
            kwl_pkg::MODE_EQ:   kd = kwl_pkg::KIND_DEF;
            kwl_pkg::MODE_DASH: kd = kwl_pkg::KIND_MINUS;
            kwl_pkg::MODE_BAR:  kd = kwl_pkg::KIND_PIPE;
            default:            kd = kwl_pkg::KIND_ERR;
        endcase
        return kd;
    endfunction

    function automatic kwl_pkg::kind_t pair_kind(input kwl_pkg::mode_t m,
                                                 input logic [7:0] c);
        kwl_pkg::kind_t kd;
        priority if (m == kwl_pkg::MODE_LT && c == "=")
            kd = kwl_pkg::KIND_LE;
        else if (m == kwl_pkg::MODE_GT && c == "=")
            kd = kwl_pkg::KIND_GE;
        else if (m == kwl_pkg::MODE_BANG && c == "=")
            kd = kwl_pkg::KIND_NE;
        else if (m == kwl_pkg::MODE_EQ && c == ">")
            kd = kwl_pkg::KIND_FAT_ARROW;
        else if (m == kwl_pkg::MODE_EQ && c == "=")
            kd = kwl_pkg::KIND_EQ;
        else if (m == kwl_pkg::MODE_DASH && c == ">")
            kd = kwl_pkg::KIND_ARROW;
        else if (m == kwl_pkg::MODE_AMP && c == "&")
            kd = kwl_pkg::KIND_AND;
        else if (m == kwl_pkg::MODE_BAR && c == "|")
            kd = kwl_pkg::KIND_OR;
        else
            kd = kwl_pkg::KIND_ERR;
        return kd;
    endfunction

    logic [7:0]                      c;
    logic [kwl_pkg::OFFSET_BITS-1:0] pos;
    kwl_pkg::lex_state_t             st0;
    kwl_pkg::lex_state_t             fr_st;
    logic                            fr_v;
    kwl_pkg::kind_t                  fr_kind;
    kwl_pkg::kind_t                  pk;
    logic                            first_v;
    logic                            second_v;
    kwl_pkg::token_t                 first_tok;
    kwl_pkg::token_t                 second_tok;
    kwl_pkg::token_t                 fr_tok;

    assign c   = beat.in_byte;
    assign pos = cur.byte_pos;
    assign pk  = pair_kind(cur.mode, c);

    // byte taken from the idle mode
    always_comb
    begin
        st0             = cur;
        st0.mode        = kwl_pkg::MODE_IDENT;
        st0.digits_only = 1'b1;
        st0.upper_first = 1'b0;
        st0.kw_alive    = '1;
        st0.pend_len    = '0;
        st0.pend_start  = pos;
        fr_st           = cur;
        fr_st.mode      = kwl_pkg::MODE_IDLE;
        fr_v            = 1'b0;
        fr_kind         = kwl_pkg::KIND_ERR;
        if (kwl_pkg::is_space(c))
        begin
            fr_v = 1'b0;
        end
        else if (kwl_pkg::name_char(c))
        begin
            fr_st = add_char(st0, c);
        end
        else
        begin
            fr_st.pend_start = pos;
            unique case (c)
                "<":     fr_st.mode = kwl_pkg::MODE_LT;
                ">":     fr_st.mode = kwl_pkg::MODE_GT;
                "!":     fr_st.mode = kwl_pkg::MODE_BANG;
                "=":     fr_st.mode = kwl_pkg::MODE_EQ;
                "-":     fr_st.mode = kwl_pkg::MODE_DASH;
                "&":     fr_st.mode = kwl_pkg::MODE_AMP;
                "|":     fr_st.mode = kwl_pkg::MODE_BAR;
                "(":     begin fr_v = 1'b1; fr_kind = kwl_pkg::KIND_LPAREN;    end
                ")":     begin fr_v = 1'b1; fr_kind = kwl_pkg::KIND_RPAREN;    end
                ":":     begin fr_v = 1'b1; fr_kind = kwl_pkg::KIND_COLON;     end
                ";":     begin fr_v = 1'b1; fr_kind = kwl_pkg::KIND_SEMICOLON; end
                "+":     begin fr_v = 1'b1; fr_kind = kwl_pkg::KIND_PLUS;      end
                "*":     begin fr_v = 1'b1; fr_kind = kwl_pkg::KIND_MUL;       end
                "/":     begin fr_v = 1'b1; fr_kind = kwl_pkg::KIND_DIV;       end
                "%":     begin fr_v = 1'b1; fr_kind = kwl_pkg::KIND_MOD;       end
                default:
                begin
                    fr_v          = 1'b1;
                    fr_kind       = kwl_pkg::KIND_ERR;
                    fr_st.stopped = 1'b1;
                end
            endcase
        end
        fr_tok = '{token_kind: fr_kind, token_offset: pos, token_size: 16'd1,
                   last_of_run: 1'b0};
    end

    always_comb
    begin
        nxt        = cur;
        first_v    = 1'b0;
        second_v   = 1'b0;
        first_tok  = '{token_kind: ident_kind(cur), token_offset: cur.pend_start,
                       token_size: cur.pend_len, last_of_run: 1'b0};
        second_tok = fr_tok;
        if (cur.stopped)
        begin
            nxt = cur;
        end
        else if (beat.end_of_text)
        begin
            if (cur.mode == kwl_pkg::MODE_IDENT)
            begin
                first_v = 1'b1;
            end
            else if (cur.mode == kwl_pkg::MODE_AMP)
            begin
                first_v   = 1'b1;
                first_tok = '{token_kind: kwl_pkg::KIND_ERR, token_offset: pos,
                              token_size: 16'd0, last_of_run: 1'b0};
            end
            else if (cur.mode != kwl_pkg::MODE_IDLE)
            begin
                first_v   = 1'b1;
                first_tok = '{token_kind: single_kind(cur.mode), token_offset: cur.pend_start,
                              token_size: 16'd1, last_of_run: 1'b0};
            end
            second_v    = (cur.mode != kwl_pkg::MODE_AMP);
            second_tok  = '{token_kind: kwl_pkg::KIND_EOF, token_offset: pos,
                            token_size: 16'd0, last_of_run: 1'b0};
            nxt.mode    = kwl_pkg::MODE_IDLE;
            nxt.stopped = 1'b1;
        end
        else
        begin
            if (cur.mode == kwl_pkg::MODE_IDENT)
            begin
                if (kwl_pkg::name_char(c))
                begin
                    nxt = add_char(cur, c);
                end
                else
                begin
                    first_v  = 1'b1;
                    nxt      = fr_st;
                    second_v = fr_v;
                end
            end
            else if (cur.mode != kwl_pkg::MODE_IDLE)
            begin
                if (pk != kwl_pkg::KIND_ERR)
                begin
                    first_v   = 1'b1;
                    first_tok = '{token_kind: pk, token_offset: cur.pend_start,
                                  token_size: 16'd2, last_of_run: 1'b0};
                    nxt.mode  = kwl_pkg::MODE_IDLE;
                end
                else if (cur.mode == kwl_pkg::MODE_AMP)
                begin
                    first_v     = 1'b1;
                    first_tok   = '{token_kind: kwl_pkg::KIND_ERR, token_offset: pos,
                                    token_size: 16'd1, last_of_run: 1'b0};
                    nxt.mode    = kwl_pkg::MODE_IDLE;
                    nxt.stopped = 1'b1;
                end
                else
                begin
                    first_v   = 1'b1;
                    first_tok = '{token_kind: single_kind(cur.mode),
                                  token_offset: cur.pend_start,
                                  token_size: 16'd1, last_of_run: 1'b0};
                    nxt       = fr_st;
                    second_v  = fr_v;
                end
            end
            else
            begin
                nxt      = fr_st;
                second_v = fr_v;
            end
            nxt.byte_pos = pos + 1'b1;
        end
    end

    // pack results into the low slot first
    always_comb
    begin
        res.v0             = first_v | second_v;
        res.v1             = first_v & second_v;
        res.t0             = first_v ? first_tok : second_tok;
        res.t0.last_of_run = !(first_v & second_v);
        res.t1             = second_tok;
        res.t1.last_of_run = 1'b1;
    end

endmodule

`default_nettype wire

// ===== sv/kwl_outbuf.sv =====
// kwl_outbuf: small token queue taking up to two tokens per cycle
`default_nettype none

module kwl_outbuf (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      push_en,
    input  wire kwl_pkg::tok_pair_t  push,
    output logic                     room,
    output logic [kwl_pkg::PTR_W:0]  level,
    output logic                     tok_valid,
    input  wire                      tok_ready,
    output kwl_pkg::token_t          tok_data
);

    kwl_pkg::token_t              mem [kwl_pkg::OBUF_DEPTH];
    logic [kwl_pkg::PTR_W-1:0]    wr_ptr_reg;
    logic [kwl_pkg::PTR_W-1:0]    wr_ptr_next;
    logic [kwl_pkg::PTR_W-1:0]    rd_ptr_reg;
    logic [kwl_pkg::PTR_W-1:0]    rd_ptr_next;
    logic [kwl_pkg::PTR_W:0]      count_reg;
    logic [kwl_pkg::PTR_W:0]      count_next;
    logic [kwl_pkg::PTR_W:0]      n_push;
    logic                         pop;

    assign tok_valid = (count_reg != '0);
    assign tok_data  = mem[rd_ptr_reg];
    assign pop       = tok_valid & tok_ready;
    assign room      = (count_reg <= (kwl_pkg::PTR_W+1)'(kwl_pkg::OBUF_DEPTH - 2));
    assign level     = count_reg;

    always_comb
    begin
        n_push      = push_en ? ((kwl_pkg::PTR_W+1)'(push.v0)
                                 + (kwl_pkg::PTR_W+1)'(push.v1)) : '0;
        wr_ptr_next = wr_ptr_reg + n_push[kwl_pkg::PTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + kwl_pkg::PTR_W'(pop);
        count_next  = count_reg + n_push - (kwl_pkg::PTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_en && push.v0)
        begin
            mem[wr_ptr_reg] <= push.t0;
        end
        if (push_en && push.v1)
        begin
            mem[wr_ptr_reg + kwl_pkg::PTR_W'(1)] <= push.t1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/keyword_lexer_top.sv =====
// keyword_lexer_top: byte-serial lexer giving kind, offset and size per token
// tokens: each token is registered into the queue when the beat that closes it is accepted
// throughput: one byte per cycle while char_ready is high; a beat may add two tokens to a four-entry queue
// char_ready drops while more than two tokens wait in that queue
// reset: asynchronous; lexer idle at offset zero, queue empty
`default_nettype none

module keyword_lexer_top (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      char_valid,
    output logic                     char_ready,
    input  wire kwl_pkg::char_beat_t char_data,
    output logic                     tok_valid,
    input  wire                      tok_ready,
    output kwl_pkg::token_t          tok_data
);

    kwl_pkg::lex_state_t     state_reg;
    kwl_pkg::lex_state_t     state_next;
    kwl_pkg::tok_pair_t      res;
    logic                    accept;
    logic                    room;
    logic [kwl_pkg::PTR_W:0] level;

    assign char_ready = room;
    assign accept     = char_valid & char_ready;

    kwl_step u_step (
        .cur  (state_reg),
        .beat (char_data),
        .nxt  (state_next),
        .res  (res)
    );

    kwl_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (accept),
        .push      (res),
        .room      (room),
        .level     (level),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_data  (tok_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kwl_pkg::LEX_RESET;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        level <= (kwl_pkg::PTR_W+1)'(kwl_pkg::OBUF_DEPTH))
        else $error("token queue overflow");

    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && state_reg.stopped) |-> !res.v0)
        else $error("token produced after stop");

    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.stopped |=> state_reg.stopped)
        else $error("stop flag cleared without reset");

    a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !state_reg.stopped && !char_data.end_of_text) |=>
        (state_reg.byte_pos == $past(state_reg.byte_pos) + 1'b1))
        else $error("byte offset did not advance");

    a_pack: assert property (@(posedge clk) disable iff (!rst_n)
        res.v1 |-> res.v0)
        else $error("second token without first");

endmodule

`default_nettype wire

// ===== tb/token_checker.sv =====
`timescale 1ns / 100ps
// token_checker: watches both channels of the keyword lexer, predicts each token and compares
module token_checker (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      char_valid,
    input  wire                      char_ready,
    input  wire kwl_pkg::char_beat_t char_data,
    input  wire                      tok_valid,
    input  wire                      tok_ready,
    input  wire kwl_pkg::token_t     tok_data,
    output int                       fail_count,
    output int                       tokens_owed
);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;

    kwl_pkg::mode_t  lex_mode;
    bit              all_digits;
    bit              caps_first;
    logic [7:0]      kw_live;
    logic [15:0]     word_len;
    logic [31:0]     word_start;
    logic [31:0]     char_pos;
    bit              halted;
    kwl_pkg::token_t tokens_due[$];
    kwl_pkg::token_t beat_tokens[$];

    function automatic string keyword_text(int k);
        case (k)
            0:       return "fun";
            1:       return "let";
            2:       return "in";
            3:       return "case";
            4:       return "of";
            5:       return "end";
            6:       return "var";
            default: return "type";
        endcase
    endfunction

    function automatic bit decimal(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit capital(logic [7:0] c);
        return c >= "A" && c <= "Z";
    endfunction

    function automatic bit word_char(logic [7:0] c);
        return c == "_" || decimal(c) || capital(c) || (c >= "a" && c <= "z");
    endfunction

    function automatic void put_token(kwl_pkg::kind_t kind, logic [31:0] at,
                                      logic [15:0] size);
        kwl_pkg::token_t t;
        t.token_kind   = kind;
        t.token_offset = at;
        t.token_size   = size;
        t.last_of_run  = 1'b0;
        beat_tokens    = {beat_tokens, t};
    endfunction

    function automatic void take_word_char(logic [7:0] c);
        string w;
        if (word_len == 0)
            caps_first = capital(c);
        if (!decimal(c))
            all_digits = 1'b0;
        for (int k = 0; k < 8; k++)
        begin
            w = keyword_text(k);
            if (word_len >= w.len() || w[word_len] != c)
                kw_live[k] = 1'b0;
        end
        if (word_len != '1)
            word_len++;
    endfunction

    function automatic kwl_pkg::kind_t word_kind();
        string w;
        if (all_digits)
            return kwl_pkg::KIND_NUMBER;
        for (int k = 0; k < 8; k++)
        begin
            w = keyword_text(k);
            if (kw_live[k] && word_len == w.len())
                return kwl_pkg::kind_t'(kwl_pkg::KIND_FUN + k);
        end
        return caps_first ? kwl_pkg::KIND_UPPERID : kwl_pkg::KIND_LOWERID;
    endfunction

    function automatic kwl_pkg::kind_t single_op_kind(kwl_pkg::mode_t m);
        case (m)
            kwl_pkg::MODE_LT:   return kwl_pkg::KIND_LT;
            kwl_pkg::MODE_GT:   return kwl_pkg::KIND_GT;
            kwl_pkg::MODE_BANG: return kwl_pkg::KIND_NOT;
            kwl_pkg::MODE_EQ:   return kwl_pkg::KIND_DEF;
            kwl_pkg::MODE_DASH: return kwl_pkg::KIND_MINUS;
            kwl_pkg::MODE_BAR:  return kwl_pkg::KIND_PIPE;
            default:            return kwl_pkg::KIND_ERR;
        endcase
    endfunction

    function automatic kwl_pkg::kind_t double_op_kind(kwl_pkg::mode_t m, logic [7:0] c);
        if (m == kwl_pkg::MODE_LT && c == "=") return kwl_pkg::KIND_LE;
        if (m == kwl_pkg::MODE_GT && c == "=") return kwl_pkg::KIND_GE;
        if (m == kwl_pkg::MODE_BANG && c == "=") return kwl_pkg::KIND_NE;
        if (m == kwl_pkg::MODE_EQ && c == ">") return kwl_pkg::KIND_FAT_ARROW;
        if (m == kwl_pkg::MODE_EQ && c == "=") return kwl_pkg::KIND_EQ;
        if (m == kwl_pkg::MODE_DASH && c == ">") return kwl_pkg::KIND_ARROW;
        if (m == kwl_pkg::MODE_AMP && c == "&") return kwl_pkg::KIND_AND;
        if (m == kwl_pkg::MODE_BAR && c == "|") return kwl_pkg::KIND_OR;
        return kwl_pkg::KIND_ERR;
    endfunction

    function automatic void fresh_char(logic [7:0] c, logic [31:0] at);
        kwl_pkg::kind_t kind;
        kind = kwl_pkg::KIND_ERR;
        lex_mode = kwl_pkg::MODE_IDLE;
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF)
            return;
        if (word_char(c))
        begin
            lex_mode   = kwl_pkg::MODE_IDENT;
            all_digits = 1'b1;
            caps_first = 1'b0;
            kw_live    = '1;
            word_len   = '0;
            word_start = at;
            take_word_char(c);
            return;
        end
        word_start = at;
        case (c)
            "<":     lex_mode = kwl_pkg::MODE_LT;
            ">":     lex_mode = kwl_pkg::MODE_GT;
            "!":     lex_mode = kwl_pkg::MODE_BANG;
            "=":     lex_mode = kwl_pkg::MODE_EQ;
            "-":     lex_mode = kwl_pkg::MODE_DASH;
            "&":     lex_mode = kwl_pkg::MODE_AMP;
            "|":     lex_mode = kwl_pkg::MODE_BAR;
            "(":     kind = kwl_pkg::KIND_LPAREN;
            ")":     kind = kwl_pkg::KIND_RPAREN;
            ":":     kind = kwl_pkg::KIND_COLON;
            ";":     kind = kwl_pkg::KIND_SEMICOLON;
            "+":     kind = kwl_pkg::KIND_PLUS;
            "*":     kind = kwl_pkg::KIND_MUL;
            "/":     kind = kwl_pkg::KIND_DIV;
            "%":     kind = kwl_pkg::KIND_MOD;
            default: kind = kwl_pkg::KIND_ERR;
        endcase
        if (lex_mode != kwl_pkg::MODE_IDLE)
            return;
        if (kind == kwl_pkg::KIND_ERR)
            halted = 1'b1;
        put_token(kind, at, 16'd1);
    endfunction

    function automatic void clear_lexer();
        lex_mode   = kwl_pkg::MODE_IDLE;
        all_digits = 1'b1;
        caps_first = 1'b0;
        kw_live    = '1;
        word_len   = '0;
        word_start = '0;
        char_pos   = '0;
        halted     = 1'b0;
        tokens_due.delete();
    endfunction

    function automatic void lex_char(kwl_pkg::char_beat_t beat);
        logic [7:0]     c;
        logic [31:0]    at;
        kwl_pkg::kind_t pair;
        c  = beat.in_byte;
        at = char_pos;
        beat_tokens.delete();
        if (halted)
            return;
        if (beat.end_of_text)
        begin
            if (lex_mode == kwl_pkg::MODE_IDENT)
                put_token(word_kind(), word_start, word_len);
            else if (lex_mode == kwl_pkg::MODE_AMP)
            begin
                put_token(kwl_pkg::KIND_ERR, at, 16'd0);
                halted = 1'b1;
            end
            else if (lex_mode != kwl_pkg::MODE_IDLE)
                put_token(single_op_kind(lex_mode), word_start, 16'd1);
            if (!halted)
                put_token(kwl_pkg::KIND_EOF, at, 16'd0);
            lex_mode = kwl_pkg::MODE_IDLE;
            halted   = 1'b1;
        end
        else
        begin
            if (lex_mode == kwl_pkg::MODE_IDENT)
            begin
                if (word_char(c))
                    take_word_char(c);
                else
                begin
                    put_token(word_kind(), word_start, word_len);
                    fresh_char(c, at);
                end
            end
            else if (lex_mode != kwl_pkg::MODE_IDLE)
            begin
                pair = double_op_kind(lex_mode, c);
                if (pair != kwl_pkg::KIND_ERR)
                begin
                    put_token(pair, word_start, 16'd2);
                    lex_mode = kwl_pkg::MODE_IDLE;
                end
                else if (lex_mode == kwl_pkg::MODE_AMP)
                begin
                    // ampersand not followed by a second one
                    put_token(kwl_pkg::KIND_ERR, at, 16'd1);
                    lex_mode = kwl_pkg::MODE_IDLE;
                    halted   = 1'b1;
                end
                else
                begin
                    put_token(single_op_kind(lex_mode), word_start, 16'd1);
                    fresh_char(c, at);
                end
            end
            else
                fresh_char(c, at);
            char_pos = at + 1;
        end
        if (beat_tokens.size() > 0)
            beat_tokens[beat_tokens.size() - 1].last_of_run = 1'b1;
        tokens_due = {tokens_due, beat_tokens};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        kwl_pkg::token_t want;
        if (!rst_n)
        begin
            clear_lexer();
            fail_count  = 0;
            tokens_owed = 0;
        end
        else
        begin
            if (tok_valid && tok_ready)
            begin
                if (tokens_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: expected none, got %0d/%0d/%0d/%0b",
                             $time, tok_data.token_kind, tok_data.token_offset,
                             tok_data.token_size, tok_data.last_of_run);
                end
                else
                begin
                    want = tokens_due.pop_front();
                    if (tok_data !== want)
                    begin
                        fail_count++;
                        $display("%0t: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                                 $time, want.token_kind, want.token_offset,
                                 want.token_size, want.last_of_run,
                                 tok_data.token_kind, tok_data.token_offset,
                                 tok_data.token_size, tok_data.last_of_run);
                    end
                end
            end
            if (char_valid && char_ready)
                lex_char(char_data);
            tokens_owed = tokens_due.size();
        end
    end

endmodule

// ===== tb/keyword_lexer_top_test.sv =====
`timescale 1ns / 100ps
// keyword_lexer_top_test: clock, reset, source text stimulus and verdict for the keyword lexer
module keyword_lexer_top_test;

    localparam int         RANDOM_CHARS = 900;
    localparam int         CYCLE_LIMIT  = 500000;
    localparam int         DRAIN_CYCLES = 20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0a;
    localparam logic [7:0] CH_CR        = 8'h0d;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                char_valid  = 1'b0;
    logic                char_ready;
    kwl_pkg::char_beat_t char_data   = '0;
    logic                tok_valid;
    logic                tok_ready   = 1'b0;
    kwl_pkg::token_t     tok_data;
    int                  fail_count;
    int                  tokens_owed;
    int                  cycle_count = 0;
    int                  burst_left  = 0;
    int                  sent        = 0;
    logic [7:0]          stall_phase = '0;

    keyword_lexer_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data),
        .tok_valid  (tok_valid),
        .tok_ready  (tok_ready),
        .tok_data   (tok_data)
    );

    token_checker token_watch (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .char_data   (char_data),
        .tok_valid   (tok_valid),
        .tok_ready   (tok_ready),
        .tok_data    (tok_data),
        .fail_count  (fail_count),
        .tokens_owed (tokens_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: always ready, then coin flips, then mostly stalled, then a square wave
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            stall_phase <= stall_phase + 1'b1;
            case (stall_phase[7:6])
                2'd0:    tok_ready <= 1'b1;
                2'd1:    tok_ready <= ($urandom_range(0, 1) == 0);
                2'd2:    tok_ready <= ($urandom_range(0, 3) == 0);
                default: tok_ready <= stall_phase[2];
            endcase
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_char(input logic [7:0] b, input logic eot);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                char_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        sent++;
        char_data  <= '{in_byte: b, end_of_text: eot};
        char_valid <= 1'b1;
        do
            @(posedge clk);
        while (!char_ready);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
    endtask

    function automatic string op_text(int i);
        case (i)
            0:       return "<=";
            1:       return "<";
            2:       return ">=";
            3:       return ">";
            4:       return "!=";
            5:       return "!";
            6:       return "=>";
            7:       return "==";
            8:       return "=";
            9:       return "->";
            10:      return "-";
            11:      return "&&";
            12:      return "||";
            13:      return "|";
            14:      return "(";
            15:      return ")";
            16:      return ":";
            17:      return ";";
            18:      return "+";
            19:      return "*";
            20:      return "/";
            default: return "%";
        endcase
    endfunction

    function automatic string keyword_word(int i);
        case (i)
            0:       return "fun";
            1:       return "let";
            2:       return "in";
            3:       return "case";
            4:       return "of";
            5:       return "end";
            6:       return "var";
            default: return "type";
        endcase
    endfunction

    function automatic logic [7:0] rand_space();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] rand_word_byte();
        case ($urandom_range(0, 6))
            0, 1:    return 8'("a" + $urandom_range(0, 25));
            2, 3:    return 8'("A" + $urandom_range(0, 25));
            4, 5:    return 8'("0" + $urandom_range(0, 9));
            default: return "_";
        endcase
    endfunction

    // bytes that neither stop the lexer nor open an ampersand pair
    function automatic bit harmless_byte(logic [7:0] b);
        if (b == "_" || (b >= "0" && b <= "9") || (b >= "a" && b <= "z") ||
            (b >= "A" && b <= "Z"))
            return 1'b1;
        case (b)
            CH_SPACE, CH_TAB, CH_CR, CH_LF,
            "<", ">", "!", "=", "-", "|", "(", ")", ":", ";", "+", "*", "/", "%":
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic send_piece();
        string       w;
        int          n;
        logic [7:0]  b;
        n = $urandom_range(0, 99);
        if (n < 25)
        begin
            w = keyword_word($urandom_range(0, 7));
            case ($urandom_range(0, 9))
                0, 1:    send_text(w.substr(0, w.len() - 2));
                2, 3:
                begin
                    send_text(w);
                    send_char(rand_word_byte(), 1'b0);
                end
                default: send_text(w);
            endcase
        end
        else if (n < 45)
        begin
            repeat ($urandom_range(1, 10))
                send_char(rand_word_byte(), 1'b0);
        end
        else if (n < 55)
        begin
            repeat ($urandom_range(1, 9))
                send_char(8'("0" + $urandom_range(0, 9)), 1'b0);
        end
        else if (n < 80)
            send_text(op_text($urandom_range(0, 21)));
        else if (n < 90)
        begin
            repeat ($urandom_range(1, 3))
                send_char(rand_space(), 1'b0);
        end
        else
        begin
            repeat ($urandom_range(1, 5))
            begin
                do
                    b = 8'($urandom_range(0, 127));
                while (!harmless_byte(b));
                send_char(b, 1'b0);
            end
        end
        if ($urandom_range(0, 1) == 0)
            send_char(rand_space(), 1'b0);
    endtask

    initial
    begin
        logic [7:0] b;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // operator pairs, lookahead misses, single-character tokens and tab, CR and LF separators
        send_text("<=<a>=>b!=!c=>===->-d&&|||(");
        send_char(CH_TAB, 1'b0);
        send_text(")*/%+:;");
        send_char(CH_CR, 1'b0);
        send_char(CH_LF, 1'b0);

        while (sent < RANDOM_CHARS)
            send_piece();

        case ($urandom_range(0, 3))
            0:
                send_char(8'($urandom_range(0, 255)), 1'b1);
            1:
            begin
                case ($urandom_range(0, 2))
                    0:       b = 8'h00;
                    1:       b = 8'hff;
                    default:
                    begin
                        do
                            b = 8'($urandom_range(0, 255));
                        while (harmless_byte(b) || b == "&");
                    end
                endcase
                send_char(b, 1'b0);
            end
            2:
            begin
                send_char("&", 1'b0);
                do
                    b = 8'($urandom_range(0, 255));
                while (b == "&");
                send_char(b, 1'b0);
            end
            default:
            begin
                send_char("&", 1'b0);
                send_char(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase

        // lexer has stopped: these beats must give nothing
        send_char(8'hff, 1'b1);
        send_char(8'h80, 1'b0);
        repeat (6)
            send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        char_valid <= 1'b0;

        @(negedge clk);
        while (tokens_owed != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
sv/kwl_pkg.sv
sv/kwl_step.sv
sv/kwl_outbuf.sv
sv/keyword_lexer_top.sv
tb/token_checker.sv
tb/keyword_lexer_top_test.sv
